// ===== rtl/dltq_pkg.sv =====
// Shared constants, types and codes for the delta-list timer queue.
`timescale 1ns / 1ps
package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DELTA_W     = 33;
    localparam int RATE_W      = 21;
    localparam int DELAY_W     = 32;
    localparam int TICKS_W     = 32;
    localparam int SEC_W       = 64;
    localparam int PROD_W      = DELAY_W + RATE_W;
    localparam int QUO_W       = 34;
    localparam int REM_W       = PROD_W + 1;
    localparam int ENTRY_W     = TAG_BITS + DELTA_W;
    localparam int US_PER_SEC  = 1000000;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_EXPIRED   = 3'd1,
        KIND_INSERTED  = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_CANCELLED = 3'd4,
        KIND_NOTFOUND  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [TAG_BITS-1:0]       tag;
        logic signed [DELTA_W-1:0] delta;
    } t_entry;

    typedef struct packed {
        logic               start;
        logic [DELAY_W-1:0] delay;
        logic [RATE_W-1:0]  rate;
    } t_conv_req;

endpackage

// ===== rtl/dltq_in_if.sv =====
// Command word channel into the timer queue.
`timescale 1ns / 1ps
interface dltq_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [7:0]                    event_tag;
    logic [dltq_pkg::DELAY_W-1:0]  delay_us;

    modport source (output valid, cmd, event_tag, delay_us, input ready);
    modport sink   (input valid, cmd, event_tag, delay_us, output ready);
endinterface

// ===== rtl/dltq_out_if.sv =====
// Result word channel out of the timer queue.
`timescale 1ns / 1ps
interface dltq_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   result_kind;
    logic [7:0]                   result_tag;
    logic [dltq_pkg::SEC_W-1:0]   uptime_seconds;
    logic [dltq_pkg::RATE_W-1:0]  subsecond_ticks;
    logic                         last_result;

    modport source (output valid, result_kind, result_tag, uptime_seconds,
                    subsecond_ticks, last_result, input ready);
    modport sink   (input valid, result_kind, result_tag, uptime_seconds,
                    subsecond_ticks, last_result, output ready);
endinterface

// ===== rtl/dltq_ram.sv =====
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/dltq_conv.sv =====
// Delay conversion: microseconds times rate over one million, by reciprocal multiplication.
`timescale 1ns / 1ps
module dltq_conv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dltq_pkg::t_conv_req            i_req,
    output logic                           o_done,
    output logic [dltq_pkg::TICKS_W-1:0]   o_ticks
);
    // floor(x / 1000000) equals (x * RECIP) >> RECIP_SH for every 32-bit x
    localparam logic [30:0] RECIP    = 31'h431B_DE83;
    localparam int          RECIP_SH = 50;
    localparam int          QD_W     = dltq_pkg::QUO_W - dltq_pkg::RATE_W;

    logic                           r_run;
    logic                           r_done;
    logic                           r_ph;
    logic [1:0]                     r_dig;
    logic [31:0]                    r_x;
    logic [dltq_pkg::RATE_W-1:0]    r_lo;
    logic [QD_W-1:0]                r_qd;
    logic [dltq_pkg::QUO_W-1:0]     r_q;
    logic [dltq_pkg::PROD_W-1:0]    w_prod;
    logic [31:0]                    w_qm;
    logic [19:0]                    w_rem;

    assign w_prod = dltq_pkg::PROD_W'(i_req.delay) * dltq_pkg::PROD_W'(i_req.rate);
    assign w_qm   = 32'(r_qd) * 32'(dltq_pkg::US_PER_SEC);
    assign w_rem  = 20'(r_x - w_qm);

    // Long division in three digits: top 32 product bits, then 12, then 9 more.
    // Each digit takes a reciprocal multiply, then a remainder step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_run) begin
                if (i_req.start) begin
                    r_run <= 1'b1;
                    r_ph  <= 1'b0;
                    r_dig <= 2'd0;
                    r_q   <= '0;
                    r_x   <= w_prod[dltq_pkg::PROD_W-1:dltq_pkg::RATE_W];
                    r_lo  <= w_prod[dltq_pkg::RATE_W-1:0];
                end
            end else if (!r_ph) begin
                r_qd <= QD_W'((64'(r_x) * 64'(RECIP)) >> RECIP_SH);
                r_ph <= 1'b1;
            end else begin
                r_ph <= 1'b0;
                case (r_dig)
                    2'd0: begin
                        r_q[dltq_pkg::QUO_W-1:dltq_pkg::RATE_W] <= r_qd;
                        r_x   <= {w_rem, r_lo[20:9]};
                        r_dig <= 2'd1;
                    end
                    2'd1: begin
                        r_q[20:9] <= r_qd[11:0];
                        r_x       <= {3'b000, w_rem, r_lo[8:0]};
                        r_dig     <= 2'd2;
                    end
                    default: begin
                        r_q[8:0] <= r_qd[8:0];
                        r_run    <= 1'b0;
                        r_done   <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done  = r_done;
    assign o_ticks = (|r_q[dltq_pkg::QUO_W-1:dltq_pkg::TICKS_W]) ? '1
                                                               : r_q[dltq_pkg::TICKS_W-1:0];
endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// Top level of the delta-list timer queue: sequencer over the entry RAM.
`timescale 1ns / 1ps
// Usage:
//   i_item carries one command word (tick, insert, cancel); i_item.ready is high
//   only while the sequencer is idle. Each command yields one or more result
//   words on o_result; last_result marks the final word of a command. An unused
//   command code is dropped with no result.
//   i_cfg_wr_en / i_cfg_wr_data write the tick rate; write it only while idle.
// Sequence (from accept to the final result word being loaded):
//   insert: the delay conversion (one multiply, then three digit steps), a
//     walk over the entries, a shift of the later entries, then place and load.
//   cancel: a search of the entries, a merge of the wait into the successor when
//     there is one, a shift down of the later entries, then a load.
//   tick: an empty list answers at once; else the head is read and checked, and
//     each expiring entry is popped and answered until the head is live or the
//     list runs empty. Full queue and empty cancel answer straight from idle.
// Reset (synchronous, active low) empties the list, zeroes the counters and
//   sets the rate to 1000. The RAM is not cleared; only live entries are read.
// A stalled receiver holds the output register; the sequencer waits with the
//   next result word and does not accept a command until the last is loaded.
module delta_list_timer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [dltq_pkg::RATE_W-1:0]   i_cfg_wr_data,
    dltq_in_if.sink                       i_item,
    dltq_out_if.source                    o_result
);
    localparam int IW = dltq_pkg::IDX_W;
    localparam int CW = dltq_pkg::CNT_W;
    localparam int TW = dltq_pkg::TAG_BITS;
    localparam int DW = dltq_pkg::DELTA_W;

    typedef enum logic [4:0] {
        S_IDLE, S_CONV, S_I_RD, S_I_CHK, S_SH_RD, S_SH_WR, S_I_PUT,
        S_C_RD, S_C_CHK, S_CA_RD, S_CA_WR, S_CS_RD, S_CS_WR,
        S_T_RD, S_T_CHK, S_T_FIN, S_EMIT
    } t_state;

    t_state                        r_state;
    t_state                        r_ret;
    logic [CW-1:0]                 r_cnt;
    logic [IW-1:0]                 r_base;
    logic [CW-1:0]                 r_i;
    logic [CW-1:0]                 r_j;
    logic [CW-1:0]                 r_pos;
    logic signed [DW-1:0]          r_t;
    logic signed [DW-1:0]          r_rm;
    logic [TW-1:0]                 r_tag;
    logic                          r_first;
    logic                          r_pend_v;
    logic [TW-1:0]                 r_pend_tag;
    logic [dltq_pkg::RATE_W-1:0]   r_rate;
    logic [dltq_pkg::RATE_W-1:0]   r_tc;
    logic [dltq_pkg::SEC_W-1:0]    r_sec;
    dltq_pkg::t_kind               r_e_kind;
    logic [TW-1:0]                 r_e_tag;
    logic                          r_e_last;
    logic                          r_ov;
    logic [2:0]                    r_o_kind;
    logic [7:0]                    r_o_tag;
    logic [dltq_pkg::SEC_W-1:0]    r_o_sec;
    logic [dltq_pkg::RATE_W-1:0]   r_o_tc;
    logic                          r_o_last;

    logic                          w_acc;
    logic                          w_out_free;
    logic                          w_load;
    logic                          w_wr_en;
    logic [IW-1:0]                 w_wr_addr;
    dltq_pkg::t_entry              w_wr_data;
    logic                          w_rd_en;
    logic [IW-1:0]                 w_rd_addr;
    dltq_pkg::t_entry              w_rd;
    logic signed [DW-1:0]          w_hd;
    logic [dltq_pkg::RATE_W-1:0]   w_tc1;
    logic [CW-1:0]                 w_cnt_m1;
    logic [IW-1:0]                 w_base_p1;
    dltq_pkg::t_conv_req           w_req;
    logic                          w_conv_done;
    logic [dltq_pkg::TICKS_W-1:0]  w_ticks;

    // Map a list position to a RAM address: the list is a ring from r_base.
    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(dltq_pkg::QUEUE_DEPTH)) begin
            s = s - (CW+1)'(dltq_pkg::QUEUE_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign w_acc      = i_item.valid && i_item.ready;
    assign w_out_free = !r_ov || o_result.ready;
    assign w_load     = (r_state == S_EMIT) && w_out_free;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_hd       = w_rd.delta - (r_first ? DW'(1) : DW'(0));
    assign w_tc1      = r_tc + 1'b1;
    assign w_cnt_m1   = r_cnt - 1'b1;
    assign w_base_p1  = (r_base == IW'(dltq_pkg::QUEUE_DEPTH - 1)) ? '0 : r_base + 1'b1;

    assign w_req.start = w_acc && (i_item.cmd == dltq_pkg::CMD_INSERT) &&
                         (r_cnt < CW'(dltq_pkg::QUEUE_DEPTH));
    assign w_req.delay = i_item.delay_us;
    assign w_req.rate  = r_rate;

    dltq_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_conv_done),
        .o_ticks (w_ticks)
    );

    dltq_ram #(
        .WIDTH (dltq_pkg::ENTRY_W),
        .DEPTH (dltq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    // RAM port control: one read or one write per state, never both on an entry.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = w_rd;
        unique case (r_state)
            S_I_RD, S_C_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_base, r_i);
            end
            S_SH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_base, CW'(r_j - 1'b1));
            end
            S_CA_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_base, CW'(r_i + 1'b1));
            end
            S_CS_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_base, CW'(r_j + 1'b1));
            end
            S_T_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_base;
            end
            S_I_CHK: begin
                // the new entry lands before this one: shrink its wait
                w_wr_en         = (w_rd.delta >= r_t);
                w_wr_addr       = f_phys(r_base, r_i);
                w_wr_data.delta = w_rd.delta - r_t;
            end
            S_SH_WR, S_CS_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = f_phys(r_base, r_j);
            end
            S_I_PUT: begin
                w_wr_en         = 1'b1;
                w_wr_addr       = f_phys(r_base, r_pos);
                w_wr_data.tag   = r_tag;
                w_wr_data.delta = r_t;
            end
            S_CA_WR: begin
                // successor inherits the removed entry's remaining wait
                w_wr_en         = 1'b1;
                w_wr_addr       = f_phys(r_base, CW'(r_i + 1'b1));
                w_wr_data.delta = w_rd.delta + r_rm;
            end
            S_T_CHK: begin
                w_wr_en         = r_first && (w_hd > 0);
                w_wr_addr       = r_base;
                w_wr_data.delta = w_hd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_base   <= '0;
            r_rate   <= dltq_pkg::RATE_RESET;
            r_tc     <= '0;
            r_sec    <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            // hold the output word until taken; reload it from S_EMIT
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_tag <= TW'(i_item.event_tag);
                        r_i   <= '0;
                        r_ret <= S_IDLE;
                        case (i_item.cmd)
                            dltq_pkg::CMD_TICK: begin
                                // advance the clock, carry into seconds once
                                if (w_tc1 >= r_rate) begin
                                    r_tc  <= w_tc1 - r_rate;
                                    r_sec <= r_sec + 1'b1;
                                end else begin
                                    r_tc <= w_tc1;
                                end
                                r_first  <= 1'b1;
                                r_pend_v <= 1'b0;
                                if (r_cnt == '0) begin
                                    r_e_kind <= dltq_pkg::KIND_TICK;
                                    r_e_tag  <= '0;
                                    r_e_last <= 1'b1;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_T_RD;
                                end
                            end
                            dltq_pkg::CMD_INSERT: begin
                                if (r_cnt >= CW'(dltq_pkg::QUEUE_DEPTH)) begin
                                    r_e_kind <= dltq_pkg::KIND_FULL;
                                    r_e_tag  <= TW'(i_item.event_tag);
                                    r_e_last <= 1'b1;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_CONV;
                                end
                            end
                            dltq_pkg::CMD_CANCEL: begin
                                if (r_cnt == '0) begin
                                    r_e_kind <= dltq_pkg::KIND_NOTFOUND;
                                    r_e_tag  <= TW'(i_item.event_tag);
                                    r_e_last <= 1'b1;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_C_RD;
                                end
                            end
                            default: begin
                                // unused command: drop it
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    if (w_conv_done) begin
                        r_t <= DW'(w_ticks);
                        if (r_cnt == '0) begin
                            r_pos   <= '0;
                            r_state <= S_I_PUT;
                        end else begin
                            r_state <= S_I_RD;
                        end
                    end
                end
                S_I_RD: r_state <= S_I_CHK;
                S_I_CHK: begin
                    if (w_rd.delta >= r_t) begin
                        r_pos   <= r_i;
                        r_j     <= r_cnt;
                        r_state <= (r_cnt > r_i) ? S_SH_RD : S_I_PUT;
                    end else begin
                        r_t <= r_t - w_rd.delta;
                        r_i <= r_i + 1'b1;
                        if (CW'(r_i + 1'b1) == r_cnt) begin
                            r_pos   <= r_cnt;
                            r_state <= S_I_PUT;
                        end else begin
                            r_state <= S_I_RD;
                        end
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_j     <= r_j - 1'b1;
                    r_state <= (CW'(r_j - 1'b1) == r_pos) ? S_I_PUT : S_SH_RD;
                end
                S_I_PUT: begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_e_kind <= dltq_pkg::KIND_INSERTED;
                    r_e_tag  <= r_tag;
                    r_e_last <= 1'b1;
                    r_state  <= S_EMIT;
                end
                S_C_RD: r_state <= S_C_CHK;
                S_C_CHK: begin
                    if (w_rd.tag == r_tag) begin
                        r_rm <= w_rd.delta;
                        if (CW'(r_i + 1'b1) < r_cnt) begin
                            r_state <= S_CA_RD;
                        end else begin
                            r_cnt    <= w_cnt_m1;
                            r_e_kind <= dltq_pkg::KIND_CANCELLED;
                            r_e_tag  <= r_tag;
                            r_e_last <= 1'b1;
                            r_state  <= S_EMIT;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (CW'(r_i + 1'b1) == r_cnt) begin
                            r_e_kind <= dltq_pkg::KIND_NOTFOUND;
                            r_e_tag  <= r_tag;
                            r_e_last <= 1'b1;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_C_RD;
                        end
                    end
                end
                S_CA_RD: r_state <= S_CA_WR;
                S_CA_WR: begin
                    r_j     <= r_i;
                    r_state <= S_CS_RD;
                end
                S_CS_RD: r_state <= S_CS_WR;
                S_CS_WR: begin
                    r_j <= r_j + 1'b1;
                    if (CW'(r_j + 2'd2) < r_cnt) begin
                        r_state <= S_CS_RD;
                    end else begin
                        r_cnt    <= w_cnt_m1;
                        r_e_kind <= dltq_pkg::KIND_CANCELLED;
                        r_e_tag  <= r_tag;
                        r_e_last <= 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_T_RD: r_state <= S_T_CHK;
                S_T_CHK: begin
                    r_first <= 1'b0;
                    if (w_hd <= 0) begin
                        // pop the head; hold its tag until we know if it is last
                        r_base     <= w_base_p1;
                        r_cnt      <= w_cnt_m1;
                        r_pend_tag <= w_rd.tag;
                        r_pend_v   <= 1'b1;
                        if (r_pend_v) begin
                            r_e_kind <= dltq_pkg::KIND_EXPIRED;
                            r_e_tag  <= r_pend_tag;
                            r_e_last <= 1'b0;
                            r_ret    <= (w_cnt_m1 == '0) ? S_T_FIN : S_T_RD;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= (w_cnt_m1 == '0) ? S_T_FIN : S_T_RD;
                        end
                    end else begin
                        r_e_kind <= r_pend_v ? dltq_pkg::KIND_EXPIRED : dltq_pkg::KIND_TICK;
                        r_e_tag  <= r_pend_v ? r_pend_tag : '0;
                        r_e_last <= 1'b1;
                        r_ret    <= S_IDLE;
                        r_state  <= S_EMIT;
                    end
                end
                S_T_FIN: begin
                    r_e_kind <= dltq_pkg::KIND_EXPIRED;
                    r_e_tag  <= r_pend_tag;
                    r_e_last <= 1'b1;
                    r_ret    <= S_IDLE;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    // load the output register once it frees up
                    if (w_out_free) begin
                        r_o_kind <= r_e_kind;
                        r_o_tag  <= 8'(r_e_tag);
                        r_o_sec  <= r_sec;
                        r_o_tc   <= r_tc;
                        r_o_last <= r_e_last;
                        r_state  <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid           = r_ov;
    assign o_result.result_kind     = r_o_kind;
    assign o_result.result_tag      = r_o_tag;
    assign o_result.uptime_seconds  = r_o_sec;
    assign o_result.subsecond_ticks = r_o_tc;
    assign o_result.last_result     = r_o_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(dltq_pkg::QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + 1'b1 ||
                            r_cnt + 1'b1 == $past(r_cnt)))
        else $error("entry count moved by more than one");

    a_full_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_item.cmd == dltq_pkg::CMD_INSERT &&
         r_cnt == CW'(dltq_pkg::QUEUE_DEPTH)) |=>
        (r_state == S_EMIT && r_e_kind == dltq_pkg::KIND_FULL && r_cnt == $past(r_cnt)))
        else $error("insert into full queue not answered as full");

    a_sec_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_item.cmd == dltq_pkg::CMD_TICK) |=>
        (r_sec == $past(r_sec) || r_sec == $past(r_sec) + 1'b1))
        else $error("seconds counter jumped on a tick");
`endif
endmodule

// ===== tb/sv/dltq_tb_chan_if.sv =====
// Testbench-side helper interface: none needed beyond the RTL channels; holds shared tb types.
`timescale 1ns / 1ps
package dltq_tb_pkg;
    import dltq_pkg::*;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        tag;
        logic [SEC_W-1:0]  secs;
        logic [RATE_W-1:0] ticks;
        logic              last;
    } t_result_word;
endpackage

// ===== tb/sv/dltq_checker.sv =====
// Checker: models the delta-list timer queue and compares every result word.
`timescale 1ns / 1ps
module dltq_checker
    import dltq_pkg::*;
    import dltq_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,
    dltq_in_if                i_item,
    dltq_out_if               o_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);
    logic [RATE_W-1:0]   rate;
    logic [7:0]          q_tags [QUEUE_DEPTH];
    longint              q_deltas [QUEUE_DEPTH];
    int                  q_count;
    logic [RATE_W-1:0]   sub_ticks;
    logic [SEC_W-1:0]    seconds;
    t_result_word        expected_words [$];

    function automatic t_result_word make_word(logic [2:0] k, logic [7:0] t);
        t_result_word w;
        w.kind  = k;
        w.tag   = t;
        w.secs  = seconds;
        w.ticks = sub_ticks;
        w.last  = 1'b0;
        return w;
    endfunction

    task automatic model_command(logic [1:0] cmd, logic [7:0] tag, logic [31:0] delay);
        t_result_word words [$];
        longint unsigned prod;
        longint t;
        int pos;
        bit hit;
        if (cmd == CMD_TICK) begin
            sub_ticks = sub_ticks + 1'b1;
            if (sub_ticks >= rate) begin
                seconds   = seconds + 1;
                sub_ticks = sub_ticks - rate;
            end
            if (q_count > 0) begin
                q_deltas[0]--;
                while (q_count > 0 && q_deltas[0] <= 0 && words.size() < QUEUE_DEPTH) begin
                    words.push_back(make_word(KIND_EXPIRED, q_tags[0]));
                    for (int j = 0; j + 1 < q_count; j++) begin
                        q_tags[j]   = q_tags[j+1];
                        q_deltas[j] = q_deltas[j+1];
                    end
                    q_count--;
                end
            end
            if (words.size() == 0) words.push_back(make_word(KIND_TICK, 8'd0));
        end else if (cmd == CMD_INSERT) begin
            prod = longint'(delay) * longint'(rate);
            prod = prod / US_PER_SEC;
            t = (prod > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : prod;
            if (q_count >= QUEUE_DEPTH) begin
                words.push_back(make_word(KIND_FULL, tag));
            end else begin
                pos = q_count;
                for (int i = 0; i < q_count; i++) begin
                    if (q_deltas[i] >= t) begin
                        q_deltas[i] -= t;
                        pos = i;
                        break;
                    end
                    t -= q_deltas[i];
                end
                for (int i = q_count; i > pos; i--) begin
                    q_tags[i]   = q_tags[i-1];
                    q_deltas[i] = q_deltas[i-1];
                end
                q_tags[pos]   = tag;
                q_deltas[pos] = t;
                q_count++;
                words.push_back(make_word(KIND_INSERTED, tag));
            end
        end else if (cmd == CMD_CANCEL) begin
            hit = 1'b0;
            for (int i = 0; i < q_count && !hit; i++) begin
                if (q_tags[i] == tag) begin
                    hit = 1'b1;
                    if (i + 1 < q_count) q_deltas[i+1] += q_deltas[i];
                    for (int j = i; j + 1 < q_count; j++) begin
                        q_tags[j]   = q_tags[j+1];
                        q_deltas[j] = q_deltas[j+1];
                    end
                    q_count--;
                end
            end
            words.push_back(make_word(hit ? KIND_CANCELLED : KIND_NOTFOUND, tag));
        end
        if (words.size() > 0) words[words.size()-1].last = 1'b1;
        foreach (words[i]) expected_words.push_back(words[i]);
    endtask

    always @(posedge i_clk) begin
        t_result_word exp_w;
        if (!i_rst_n) begin
            rate      = RATE_RESET;
            q_count   = 0;
            sub_ticks = '0;
            seconds   = '0;
            expected_words.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word kind %0d", o_result.result_kind);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_result.result_kind !== exp_w.kind ||
                        o_result.result_tag !== exp_w.tag ||
                        o_result.uptime_seconds !== exp_w.secs ||
                        o_result.subsecond_ticks !== exp_w.ticks ||
                        o_result.last_result !== exp_w.last) begin
                        if (o_result.result_kind !== exp_w.kind)
                            $error("result_kind exp %0d got %0d", exp_w.kind,
                                   o_result.result_kind);
                        if (o_result.result_tag !== exp_w.tag)
                            $error("result_tag exp %0d got %0d", exp_w.tag,
                                   o_result.result_tag);
                        if (o_result.uptime_seconds !== exp_w.secs)
                            $error("uptime_seconds exp %0d got %0d", exp_w.secs,
                                   o_result.uptime_seconds);
                        if (o_result.subsecond_ticks !== exp_w.ticks)
                            $error("subsecond_ticks exp %0d got %0d", exp_w.ticks,
                                   o_result.subsecond_ticks);
                        if (o_result.last_result !== exp_w.last)
                            $error("last_result exp %0d got %0d", exp_w.last,
                                   o_result.last_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_item.valid && i_item.ready)
                model_command(i_item.cmd, i_item.event_tag, i_item.delay_us);
            if (i_cfg_wr_en) rate = i_cfg_wr_data;
        end
        o_pending <= expected_words.size();
    end
endmodule

// ===== tb/sv/delta_list_timer_queue_tb.sv =====
// Testbench top: drives command words and rate writes, gives the verdict.
`timescale 1ns / 1ps
module delta_list_timer_queue_tb;
    import dltq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [RATE_W-1:0] i_cfg_wr_data;
    int                fail_count;
    int                pending;
    int                result_count;
    int                idle_cycles;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_off_cycles;
    int                items_sent;

    dltq_in_if  in_ch ();
    dltq_out_if out_ch ();

    delta_list_timer_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (in_ch),
        .o_result      (out_ch)
    );

    dltq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_item         (in_ch),
        .o_result       (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: stall at the current phase rate, or hold off entirely while
    // a long hold-off is counting down.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ch.ready    <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("delta_list_timer_queue: mismatch");
            $finish;
        end
    end

    // Offer one word, with a random idle gap first; hold it until accepted.
    task automatic send_word(logic [1:0] cmd, logic [7:0] tag, logic [31:0] delay);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.event_tag <= tag;
        in_ch.delay_us  <= delay;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and wait for every expected word, plus the block's latency.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly inserts with small delays and ticks so entries expire often;
    // some cancels of live-ish tags and some unused-command noise.
    task automatic random_word();
        int sel;
        logic [31:0] delay;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0) delay = $urandom();
        else delay = $urandom_range(20000);
        if (sel < 35)      send_word(CMD_TICK, 8'($urandom()), $urandom());
        else if (sel < 70) send_word(CMD_INSERT, 8'($urandom_range(15)), delay);
        else if (sel < 92) send_word(CMD_CANCEL, 8'($urandom_range(17)), $urandom());
        else               send_word(CMD_UNUSED, 8'($urandom()), $urandom());
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_TICK;
        in_ch.event_tag = '0;
        in_ch.delay_us  = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, not-found cancel, extremes of tag and delay,
        // equal waits, duplicate tags, unused command.
        send_word(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_CANCEL, 8'hFF, 32'd0);
        send_word(CMD_INSERT, 8'h00, 32'd0);
        send_word(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 8'h05, 32'd3000);
        send_word(CMD_INSERT, 8'h06, 32'd3000);
        send_word(CMD_INSERT, 8'h05, 32'd3000);
        send_word(CMD_UNUSED, 8'hAA, 32'h5555_5555);
        send_word(CMD_CANCEL, 8'h05, 32'd0);
        send_word(CMD_TICK, 8'h00, 32'd0);
        repeat (4) send_word(CMD_TICK, 8'h00, 32'd0);
        // Fill the queue past capacity to get queue-full answers.
        for (int i = 0; i < 16; i++) send_word(CMD_INSERT, 8'(i), 32'(i * 1000));
        send_word(CMD_CANCEL, 8'hFF, 32'd0);

        // A high rate makes the huge delay saturate; a low rate later rolls seconds.
        write_rate(21'd1193182);
        send_word(CMD_INSERT, 8'h80, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 8'h00, 32'd0);

        // Long receiver hold-off while the sender keeps offering words.
        hold_off_cycles = 400;
        for (int i = 0; i < 8; i++) send_word(CMD_TICK, 8'h00, 32'd0);

        write_rate(21'd19);
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int i = 0; i < 22; i++) random_word();
            // Pause until every expected word is back, then change the rate.
            case (p)
                0: write_rate(21'd1000);
                1: write_rate(21'd0);
                2: write_rate(21'($urandom_range(19, 1193182)));
                default: write_rate(21'd19);
            endcase
        end
        // Widest rate the register holds, with a few ticks.
        write_rate(21'h1FFFFF);
        for (int i = 0; i < 3; i++) send_word(CMD_TICK, 8'h00, 32'd0);
        drain();

        $display("Covered %0d command words and %0d result words over several rates,",
                 items_sent, result_count);
        $display("four idle/stall phases, one long receiver hold-off and full-queue inserts.");
        if (fail_count == 0)
            $display("delta_list_timer_queue: match");
        else
            $display("delta_list_timer_queue: mismatch");
        $finish;
    end
endmodule
